/* rtl/core/cesc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesc_pkg
// Types and constants shared by the escape-to-UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package cesc_pkg;

    // Window geometry: five held bytes plus the incoming one
    localparam int WIN_LEN  = 6;
    localparam int HOLD_LEN = 5;
    localparam int CNT_W    = 3;

    // Characters of the escape prefix
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    // UTF-8 bytes for code points 0x400..0x47F
    localparam logic [7:0] LEAD_LO    = 8'hD0;
    localparam logic [7:0] LEAD_HI    = 8'hD1;
    localparam logic [7:0] TRAIL_BASE = 8'h80;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } out_t;

    // Result group of one input item, oldest result in entry 0
    typedef struct packed {
        byte_t [WIN_LEN-1:0] res_bytes;
        logic [CNT_W-1:0]    cnt;
        logic                fin;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    // Decode one lowercase hex digit
    function automatic hex_t hex_lower(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - CH_LA + 8'd10);
        end
        return h;
    endfunction

endpackage

/* rtl/core/cesc_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesc_window
// Holds up to five pending bytes, matches the six-byte escape window and
// builds the result group of each accepted byte.
// ----------------------------------------------------------------------------
module cesc_window (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  cesc_pkg::in_t  item,
    output cesc_pkg::res_t res
);

    localparam int CNT_W = cesc_pkg::CNT_W;

    cesc_pkg::byte_t [cesc_pkg::HOLD_LEN-1:0] pend_reg, pend_next;
    logic [cesc_pkg::CNT_W-1:0]               cnt_reg, cnt_next;

    cesc_pkg::byte_t [cesc_pkg::WIN_LEN-1:0]  win;
    cesc_pkg::hex_t                           hi_h, lo_h;
    logic                                     full, prefix_ok, in_set, match;
    cesc_pkg::byte_t                          lead, trail;

    // Assemble the window: held bytes, then the incoming byte
    always_comb begin
        for (int i = 0; i < cesc_pkg::HOLD_LEN; i++) begin
            win[i] = (CNT_W'(i) < cnt_reg) ? pend_reg[i] : item.in_byte;
        end
        win[cesc_pkg::WIN_LEN-1] = item.in_byte;
    end

    // Match the escape pattern on a full window
    assign full      = (cnt_reg == CNT_W'(cesc_pkg::HOLD_LEN));
    assign prefix_ok = (win[0] == cesc_pkg::CH_BSLASH) && (win[1] == cesc_pkg::CH_U)
                    && (win[2] == cesc_pkg::CH_ZERO)   && (win[3] == cesc_pkg::CH_FOUR);
    assign hi_h      = cesc_pkg::hex_lower(win[4]);
    assign lo_h      = cesc_pkg::hex_lower(win[5]);
    assign in_set    = ((hi_h.nib >= 4'd1) && (hi_h.nib <= 4'd4))
                    || ((lo_h.nib == 4'd1) && ((hi_h.nib == 4'd0) || (hi_h.nib == 4'd5)));
    assign match     = full && prefix_ok && hi_h.ok && lo_h.ok && in_set;

    // Code points below 0x440 lead with D0, the rest with D1
    assign lead  = (hi_h.nib < 4'd4) ? cesc_pkg::LEAD_LO : cesc_pkg::LEAD_HI;
    assign trail = cesc_pkg::TRAIL_BASE | {2'b00, hi_h.nib[1:0], lo_h.nib};

    // Build the result group
    always_comb begin
        res.res_bytes = win;
        res.fin       = item.in_final;
        priority if (match) begin
            res.res_bytes[0] = lead;
            res.res_bytes[1] = trail;
            res.cnt          = CNT_W'(2);
        end else if (item.in_final) begin
            res.cnt = cnt_reg + CNT_W'(1);
        end else if (full) begin
            res.cnt = CNT_W'(1);
        end else begin
            res.cnt = '0;
        end
    end

    // Advance the pending window
    always_comb begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            priority if (match || item.in_final) begin
                cnt_next = '0;
            end else if (full) begin
                for (int j = 0; j < cesc_pkg::HOLD_LEN; j++) begin
                    pend_next[j] = win[j+1];
                end
            end else begin
                pend_next[cnt_reg] = item.in_byte;
                cnt_next           = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        pend_reg <= pend_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(cesc_pkg::HOLD_LEN))
        else $error("pending count above hold depth");

    a_match_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load && match |=> cnt_reg == '0)
        else $error("window not cleared after a match");

    a_full_slides: assert property (@(posedge aclk) disable iff (!aresetn)
        load && full && !match && !item.in_final |=> cnt_reg == CNT_W'(cesc_pkg::HOLD_LEN))
        else $error("full window did not slide");
`endif

endmodule

/* rtl/core/cesc_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cesc_outbuf
// Result register: takes one result group and drains it one byte per
// transfer on the result channel.
// ----------------------------------------------------------------------------
module cesc_outbuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  cesc_pkg::res_t res,
    output logic           take_ok,
    output logic           m_valid,
    input  logic           m_ready,
    output cesc_pkg::out_t m_data
);

    localparam int CNT_W = cesc_pkg::CNT_W;

    cesc_pkg::byte_t [cesc_pkg::WIN_LEN-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]                        left_reg, left_next;
    logic                                    fin_reg, fin_next;
    logic                                    pop;

    // Present the head byte
    assign m_valid             = (left_reg != '0);
    assign m_data.out_byte     = buf_reg[0];
    assign m_data.run_last     = (left_reg == CNT_W'(1));
    assign m_data.stream_end   = (left_reg == CNT_W'(1)) && fin_reg;
    assign pop                 = m_valid && m_ready;

    // Take a new group once the current one is gone by the end of this cycle
    assign take_ok = (left_reg == '0) || ((left_reg == CNT_W'(1)) && m_ready);

    // Shift out on transfer, reload on a new group
    always_comb begin
        buf_next  = buf_reg;
        left_next = left_reg;
        fin_next  = fin_reg;
        if (pop) begin
            for (int i = 0; i < cesc_pkg::WIN_LEN - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            left_next = left_reg - CNT_W'(1);
        end
        if (load) begin
            buf_next  = res.res_bytes;
            left_next = res.cnt;
            fin_next  = res.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
        buf_reg <= buf_next;
        fin_reg <= fin_next;
    end

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= CNT_W'(cesc_pkg::WIN_LEN))
        else $error("result count above window length");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(left_reg) && $stable(buf_reg[0]))
        else $error("result changed while stalled");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (res.cnt != '0) |=> m_valid)
        else $error("loaded result group not presented");
`endif

endmodule

/* rtl/core/cyrillic_escape_to_utf8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyrillic_escape_to_utf8
// Replaces \u04XX escapes of Cyrillic letters in a byte stream by UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one text byte per transfer plus an end-of-string flag.
//   m_ channel carries output bytes; run_last marks the last byte caused by
//   one input transfer, stream_end the last byte of the whole string.
//   A byte that completes a matching six-byte escape yields two bytes; a
//   byte that fills a non-matching window yields the oldest held byte; other
//   bytes yield nothing until the end flag, which flushes every held byte.
// Output: a result is registered and appears on m_ the cycle after its input.
// Throughput: one input byte per cycle while each input yields at most one
//   result and m_ready is high; an input yielding N results holds s_ready low
//   until the result register, draining a byte per transfer, has one left.
// Reset: aresetn (synchronous, active low) empties the held window and the
//   result register.
// Stall: while m_ready is low the head result holds, and s_ready stays low
//   once the pending result group cannot drain in the current cycle.
// ----------------------------------------------------------------------------
module cyrillic_escape_to_utf8 (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cesc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cesc_pkg::out_t m_data
);

    cesc_pkg::res_t res;
    logic           load;

    // Accept an input transfer when the result register frees up
    assign load = s_valid && s_ready;

    cesc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .item    (s_data),
        .res     (res)
    );

    cesc_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res     (res),
        .take_ok (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/utf8_decode_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_monitor
// Watches both channels of the escape-to-UTF-8 decoder. Each input transfer
// runs through a local model of the six-byte window. The bytes it yields are
// queued in order and compared with every output transfer.
// ----------------------------------------------------------------------------
module utf8_decode_monitor
    import cesc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_t         s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_t        m_data,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    byte_t       held_bytes [HOLD_LEN];
    int          held_cnt;
    int unsigned err_total;
    out_t        utf8_expect [$];

    // Value of a lowercase hex digit, -1 for anything else
    function automatic int lc_nibble(input byte_t c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LA && c <= CH_LF) begin
            return int'(c - CH_LA) + 10;
        end
        return -1;
    endfunction

    // Code point of a matching escape window, zero when the window does not match
    function automatic int escape_code_point(input byte_t [WIN_LEN-1:0] win);
        int hi;
        int lo;
        int val;
        if (win[0] != CH_BSLASH || win[1] != CH_U || win[2] != CH_ZERO ||
            win[3] != CH_FOUR) begin
            return 0;
        end
        hi = lc_nibble(win[4]);
        lo = lc_nibble(win[5]);
        if (hi < 0 || lo < 0) begin
            return 0;
        end
        val = hi * 16 + lo;
        if ((val >= 'h10 && val <= 'h4F) || val == 'h01 || val == 'h51) begin
            return 'h400 + val;
        end
        return 0;
    endfunction

    // Advance the window by one input byte and queue the bytes it yields
    task automatic predict_transfer(input in_t item);
        byte_t [WIN_LEN-1:0] win;
        out_t                grp [WIN_LEN];
        int                  n;
        int                  k;
        int                  cp;
        k   = 0;
        win = '0;
        for (int i = 0; i < held_cnt; i++) begin
            win[i] = held_bytes[i];
        end
        win[held_cnt] = item.in_byte;
        n = held_cnt + 1;

        // Full window: replace a match by its UTF-8 pair, else emit the oldest byte
        if (n == WIN_LEN) begin
            cp = escape_code_point(win);
            if (cp != 0) begin
                grp[0] = '{(cp < 'h440) ? LEAD_LO : LEAD_HI, 1'b0, 1'b0};
                grp[1] = '{TRAIL_BASE | byte_t'(cp & 'h3F), 1'b0, 1'b0};
                k = 2;
                n = 0;
            end else begin
                grp[0] = '{win[0], 1'b0, 1'b0};
                k = 1;
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    win[i] = win[i + 1];
                end
                n = WIN_LEN - 1;
            end
        end

        // End of string: flush every held byte in order
        if (item.in_final) begin
            for (int i = 0; i < n; i++) begin
                grp[k] = '{win[i], 1'b0, 1'b0};
                k++;
            end
            n = 0;
        end

        for (int i = 0; i < n; i++) begin
            held_bytes[i] = win[i];
        end
        held_cnt = n;

        if (k > 0) begin
            grp[k - 1].run_last   = 1'b1;
            grp[k - 1].stream_end = item.in_final;
        end
        for (int i = 0; i < k; i++) begin
            utf8_expect.push_back(grp[i]);
        end
    endtask

    // Check output transfers first, then queue what the input transfer yields
    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            held_cnt  = 0;
            err_total = 0;
            utf8_expect.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (utf8_expect.size() == 0) begin
                    $display({"%0t: unexpected output: expected none, ",
                              "actual byte %h last %b end %b"},
                             $time, m_data.out_byte, m_data.run_last, m_data.stream_end);
                    err_total++;
                end else begin
                    want = utf8_expect.pop_front();
                    if (want.out_byte !== m_data.out_byte ||
                        want.run_last !== m_data.run_last ||
                        want.stream_end !== m_data.stream_end) begin
                        $display({"%0t: output mismatch: expected byte %h last %b end %b, ",
                                  "actual byte %h last %b end %b"},
                                 $time, want.out_byte, want.run_last, want.stream_end,
                                 m_data.out_byte, m_data.run_last, m_data.stream_end);
                        err_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_transfer(s_data);
            end
            mismatches  <= err_total;
            outstanding <= utf8_expect.size();
        end
    end

endmodule

/* tb/cyrillic_escape_to_utf8_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyrillic_escape_to_utf8_tb
// Drives byte streams into the escape-to-UTF-8 decoder: directed escapes at the
// value limits, uppercase digits and short tails, then random escapes, broken
// escapes and noise under three idling patterns. The monitor checks every
// output byte.
// ----------------------------------------------------------------------------
module cyrillic_escape_to_utf8_tb;
    import cesc_pkg::*;

    localparam int         HOLD_CYCLES = 80;
    localparam int         FIN_PCT     = 4;
    localparam int         TAIL_CYCLES = 8;
    localparam logic [7:0] UPPER_A     = 8'h41;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_t         s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_t        m_data;
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          byte_count  = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    cyrillic_escape_to_utf8 dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_decode_monitor monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // End a hung run
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Drive m_ready: a long hold-off on request, otherwise random idling
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_toggle != hold_seen) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one byte, idling first at random, and hold it until the transfer
    task automatic push_byte(input byte_t b, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, in_final: fin};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        byte_count++;
    endtask

    task automatic push_text(input string txt, input logic fin);
        for (int i = 0; i < txt.len(); i++) begin
            push_byte(txt[i], fin && (i == txt.len() - 1));
        end
    endtask

    function automatic byte_t hex_digit(input logic [3:0] nib, input logic upper);
        if (nib < 10) begin
            return CH_ZERO + nib;
        end
        return (upper ? UPPER_A : CH_LA) + nib - 8'd10;
    endfunction

    function automatic logic rand_fin();
        return $urandom_range(0, 99) < FIN_PCT;
    endfunction

    // Send a well-formed escape, a broken one or plain noise
    task automatic push_random_segment();
        byte_t      esc [WIN_LEN];
        logic [7:0] val;
        int         kind;
        int         len;
        case ($urandom_range(0, 9))
            0:       val = 8'h01;
            1:       val = 8'h51;
            2, 3, 4,
            5, 6:    val = 8'($urandom_range('h10, 'h4F));
            default: val = 8'($urandom_range(0, 255));
        endcase
        esc[0] = CH_BSLASH;
        esc[1] = CH_U;
        esc[2] = CH_ZERO;
        esc[3] = CH_FOUR;
        esc[4] = hex_digit(val[7:4], $urandom_range(0, 99) < 15);
        esc[5] = hex_digit(val[3:0], $urandom_range(0, 99) < 15);
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            len = WIN_LEN;
        end else if (kind < 82) begin
            // Truncate the escape or corrupt its prefix
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom_range(1, WIN_LEN - 1);
            end else begin
                len = WIN_LEN;
                esc[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            end
        end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                esc[i] = 8'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < len; i++) begin
            push_byte(esc[i], rand_fin());
        end
    endtask

    // Stop offering and wait for every queued result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input logic hold_off);
        int goal;
        goal        = byte_count + count;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (hold_off) begin
            hold_toggle <= ~hold_toggle;
        end
        while (byte_count < goal) begin
            push_random_segment();
        end
        drain();
    endtask

    initial begin
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: limits of the value set, uppercase digit, lone byte, short tail
        push_text("\\u0401", 1'b0);
        push_text("\\u044f", 1'b1);
        push_text("\\u044F", 1'b1);
        push_byte(8'h00, 1'b1);
        push_text("\\u04", 1'b0);
        push_byte(8'hFF, 1'b1);
        drain();

        // Random: slow receiver, then slow sender, then full rate after a hold-off
        run_phase(27, 78, 105, 1'b0);
        run_phase(78, 27, 105, 1'b0);
        run_phase(0, 0, 110, 1'b1);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
